[rtl/core/cdlr_pkg.sv]
package cdlr_pkg;

  localparam int MAX_DIMENSION = 256;
  localparam int FRACTION_BITS = 16;

  localparam int CoordW   = 12;
  localparam int DeltaW   = CoordW + 1;
  localparam int RegW     = 9;
  localparam int CfgIdxW  = 1;
  localparam int ColorW   = 16;
  localparam int AddrW    = 16;
  localparam int DimW     = $clog2(MAX_DIMENSION);
  localparam int QuotW    = FRACTION_BITS + 1;
  localparam int SlopeW   = QuotW + 1;
  localparam int ProdW    = SlopeW + DeltaW;
  localparam int SumW     = ProdW + 1;
  localparam int EndW     = SumW - FRACTION_BITS;
  localparam int AccW     = DimW + FRACTION_BITS + 2;
  localparam int DivSteps = QuotW;
  localparam int CntW     = $clog2(DivSteps);

  localparam logic [RegW-1:0] WidthReset  = 9'd256;
  localparam logic [RegW-1:0] HeightReset = 9'd192;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_e;

  typedef struct packed {
    logic start;
    logic step;
    logic div_step;
    logic mul;
    logic chk;
    logic sel;
  } cmd_t;

  typedef struct packed {
    logic zero_len;
    logic out_block;
  } status_t;

endpackage

[rtl/core/clipped_dda_line_rasterizer_top.sv]
// step transactions: one per cycle while no stalled pixel holds the input, pixel registered,
// out_valid_o in the cycle after acceptance; after a start the input stalls through
// set-up: restoring slope divider, a multiply and a check step per end; a
// zero-length line skips the division. The divider yields one quotient bit per cycle.
// reset (rst_ni low, asynchronous): no line active, no pixel pending,
// frame_width back to 256 and frame_height back to 192
module clipped_dda_line_rasterizer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic                                buffer_select_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  x_start_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  y_start_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  x_end_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  y_end_i,
  input  logic [cdlr_pkg::ColorW-1:0]         pen_color_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cdlr_pkg::AddrW-1:0]          pixel_address_o,
  output logic [cdlr_pkg::ColorW-1:0]         pixel_color_o,
  output logic                                target_buffer_o,
  output logic                                last_pixel_o,
  input  logic                                cfg_we_i,
  input  logic [cdlr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cdlr_pkg::RegW-1:0]           cfg_data_i
);
  import cdlr_pkg::*;

  cmd_t    cmd;
  status_t status;

  cdlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cdlr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .buffer_select_i (buffer_select_i),
    .x_start_i       (x_start_i),
    .y_start_i       (y_start_i),
    .x_end_i         (x_end_i),
    .y_end_i         (y_end_i),
    .pen_color_i     (pen_color_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .pixel_address_o (pixel_address_o),
    .pixel_color_o   (pixel_color_o),
    .target_buffer_o (target_buffer_o),
    .last_pixel_o    (last_pixel_o)
  );

`ifndef SYNTHESIS
  // a new pixel only follows an accepted step transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && operation_i == OP_STEP))
    else $error("pixel issued without a step transaction");

  // line set-up blocks the input side for at least the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == OP_START) |=> in_stall_o)
    else $error("input taken during line set-up");

  // set-up commands never reach the datapath together with a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !(cmd.div_step || cmd.mul || cmd.chk || cmd.start))
    else $error("step issued during line set-up");
`endif

endmodule

[rtl/core/cdlr_ctrl.sv]
module cdlr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  output logic              in_stall_o,
  input  cdlr_pkg::status_t status_i,
  output cdlr_pkg::cmd_t    cmd_o
);
  import cdlr_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL0 = 6'b000100,
    ST_CHK0 = 6'b001000,
    ST_MUL1 = 6'b010000,
    ST_CHK1 = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign in_stall_o = (state_q != ST_IDLE) || status_i.out_block;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_START) begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = ST_DIV;
          end else begin
            cmd_o.step = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (status_i.zero_len) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_step = 1'b1;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_d = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CHK0;
      end
      ST_CHK0: begin
        cmd_o.chk = 1'b1;
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul = 1'b1;
        cmd_o.sel = 1'b1;
        state_d   = ST_CHK1;
      end
      ST_CHK1: begin
        cmd_o.chk = 1'b1;
        cmd_o.sel = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/core/cdlr_datapath.sv]
module cdlr_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cdlr_pkg::cmd_t                      cmd_i,
  output cdlr_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [cdlr_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cdlr_pkg::RegW-1:0]           cfg_data_i,
  input  logic                                buffer_select_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  x_start_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  y_start_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  x_end_i,
  input  logic signed [cdlr_pkg::CoordW-1:0]  y_end_i,
  input  logic [cdlr_pkg::ColorW-1:0]         pen_color_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [cdlr_pkg::AddrW-1:0]          pixel_address_o,
  output logic [cdlr_pkg::ColorW-1:0]         pixel_color_o,
  output logic                                target_buffer_o,
  output logic                                last_pixel_o
);
  import cdlr_pkg::*;

  localparam int MinW = AccW - FRACTION_BITS;
  localparam int MulW = 2 * DimW + 1;

  function automatic logic [DimW-1:0] dim_m1(input logic [RegW-1:0] r);
    if (r == '0) begin
      return '0;
    end else if (int'(r) > MAX_DIMENSION) begin
      return DimW'(MAX_DIMENSION - 1);
    end else begin
      return DimW'(r - 1'b1);
    end
  endfunction

  function automatic logic [CoordW-1:0] mag(input logic signed [DeltaW-1:0] v);
    logic signed [DeltaW-1:0] n;
    n = -v;
    return v[DeltaW-1] ? n[CoordW-1:0] : v[CoordW-1:0];
  endfunction

  function automatic logic [DimW-1:0] clamp_end(input logic signed [CoordW-1:0] v,
                                                 input logic [DimW-1:0] hi);
    if (v[CoordW-1]) begin
      return '0;
    end else if (v > $signed({{(CoordW - DimW){1'b0}}, hi})) begin
      return hi;
    end else begin
      return v[DimW-1:0];
    end
  endfunction

  function automatic logic [DimW-1:0] clamp_minor(input logic signed [MinW-1:0] v,
                                                   input logic [DimW-1:0] hi);
    if (v[MinW-1]) begin
      return '0;
    end else if (v > $signed({{(MinW - DimW){1'b0}}, hi})) begin
      return hi;
    end else begin
      return v[DimW-1:0];
    end
  endfunction

  // configuration
  logic [RegW-1:0] width_q, height_q;
  logic [DimW-1:0] wm1, hm1;

  // line set-up
  logic                      x_major_q, dmaj_neg_q, slope_neg_q, bad0_q;
  logic signed [CoordW-1:0]  ma0_q, ma1_q, mi0_q, mi1_q;
  logic [CoordW-1:0]         d_q;
  logic [CoordW:0]           rem_q;
  logic [QuotW-1:0]          quot_q;
  logic signed [ProdW-1:0]   prod_q;
  logic [DimW-1:0]           e0_q;
  logic [ColorW-1:0]         held_color_q;
  logic                      held_buffer_q;

  // line in progress
  logic                      line_active_q, step_neg_q;
  logic [DimW-1:0]           pos_q, limit_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [SlopeW-1:0]  slope_step_q;

  // result register
  logic                      out_valid_q, last_q, buf_q;
  logic [AddrW-1:0]          addr_q;
  logic [ColorW-1:0]         color_q;

  logic signed [DeltaW-1:0]  dx, dy, dmaj, dmin;
  logic [CoordW-1:0]         adx, ady;
  logic                      xmaj;
  logic                      ge;
  logic [CoordW:0]           rem_sub;
  logic signed [SlopeW-1:0]  slope_mag, slope;
  logic [DimW-1:0]           majm1, minm1, c0, c1, c_sel;
  logic signed [CoordW-1:0]  ma_sel, mi_sel;
  logic signed [DeltaW-1:0]  clamp_dist;
  logic signed [SumW-1:0]    sum;
  logic signed [EndW-1:0]    e_end;
  logic                      bad, commit;
  logic signed [MinW-1:0]    minor;
  logic [DimW-1:0]           mc, col_pre, row_pre, col, row;
  logic [DimW:0]             wdim;
  logic [MulW-1:0]           prod_rc;
  logic [MulW:0]             addr_full;
  logic                      fire, last;

  assign wm1 = dim_m1(width_q);
  assign hm1 = dim_m1(height_q);

  assign dx   = $signed({x_end_i[CoordW-1], x_end_i}) - $signed({x_start_i[CoordW-1], x_start_i});
  assign dy   = $signed({y_end_i[CoordW-1], y_end_i}) - $signed({y_start_i[CoordW-1], y_start_i});
  assign adx  = mag(dx);
  assign ady  = mag(dy);
  assign xmaj = adx > ady;
  assign dmaj = xmaj ? dx : dy;
  assign dmin = xmaj ? dy : dx;

  // restoring division, one quotient bit per cycle
  assign ge      = rem_q >= {1'b0, d_q};
  assign rem_sub = ge ? rem_q - {1'b0, d_q} : rem_q;

  assign slope_mag = $signed({1'b0, quot_q});
  assign slope     = slope_neg_q ? -slope_mag : slope_mag;

  assign majm1  = x_major_q ? wm1 : hm1;
  assign minm1  = x_major_q ? hm1 : wm1;
  assign c0     = clamp_end(ma0_q, majm1);
  assign c1     = clamp_end(ma1_q, majm1);
  assign c_sel  = cmd_i.sel ? c1 : c0;
  assign ma_sel = cmd_i.sel ? ma1_q : ma0_q;
  assign mi_sel = cmd_i.sel ? mi1_q : mi0_q;
  assign clamp_dist = $signed({{(DeltaW - DimW){1'b0}}, c_sel}) -
                      $signed({ma_sel[CoordW-1], ma_sel});

  // minor end in fixed point, truncated toward zero
  assign sum = $signed({{(SumW - CoordW - FRACTION_BITS){mi_sel[CoordW-1]}}, mi_sel,
                        {FRACTION_BITS{1'b0}}}) + $signed({prod_q[ProdW-1], prod_q});
  assign e_end = sum[SumW-1:FRACTION_BITS] +
                 EndW'(sum[SumW-1] && (|sum[FRACTION_BITS-1:0]));
  assign bad    = e_end[EndW-1] || (e_end > $signed({{(EndW - DimW){1'b0}}, minm1}));
  assign commit = cmd_i.chk && cmd_i.sel && !bad0_q && !bad;

  // pixel of the current step
  assign minor   = acc_q[AccW-1:FRACTION_BITS];
  assign mc      = clamp_minor(minor, x_major_q ? hm1 : wm1);
  assign col_pre = x_major_q ? pos_q : mc;
  assign row_pre = x_major_q ? mc : pos_q;
  assign col     = (col_pre > wm1) ? wm1 : col_pre;
  assign row     = (row_pre > hm1) ? hm1 : row_pre;
  assign wdim    = {1'b0, wm1} + 1'b1;
  assign prod_rc = row * wdim;
  assign addr_full = {1'b0, prod_rc} + {{(MulW + 1 - DimW){1'b0}}, col};
  assign fire    = cmd_i.step && line_active_q;
  assign last    = pos_q == limit_q;

  assign status_o.zero_len  = d_q == '0;
  assign status_o.out_block = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q       <= WidthReset;
      height_q      <= HeightReset;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.start) begin
        line_active_q <= 1'b0;
      end else if (commit) begin
        line_active_q <= 1'b1;
      end else if (fire && last) begin
        line_active_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_major_q     <= xmaj;
      ma0_q         <= xmaj ? x_start_i : y_start_i;
      ma1_q         <= xmaj ? x_end_i : y_end_i;
      mi0_q         <= xmaj ? y_start_i : x_start_i;
      mi1_q         <= xmaj ? y_end_i : x_end_i;
      dmaj_neg_q    <= dmaj[DeltaW-1];
      slope_neg_q   <= dmaj[DeltaW-1] ^ dmin[DeltaW-1];
      d_q           <= xmaj ? adx : ady;
      rem_q         <= {1'b0, xmaj ? ady : adx};
      quot_q        <= '0;
      held_color_q  <= pen_color_i;
      held_buffer_q <= buffer_select_i;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[CoordW-1:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= slope * clamp_dist;
    end
    if (cmd_i.chk && !cmd_i.sel) begin
      bad0_q <= bad;
      e0_q   <= e_end[DimW-1:0];
    end
    if (commit) begin
      pos_q        <= c0;
      limit_q      <= c1;
      step_neg_q   <= dmaj_neg_q;
      acc_q        <= $signed({2'b00, e0_q, {FRACTION_BITS{1'b0}}});
      slope_step_q <= dmaj_neg_q ? -slope : slope;
    end
    if (fire) begin
      addr_q  <= AddrW'(addr_full);
      color_q <= held_color_q;
      buf_q   <= held_buffer_q;
      last_q  <= last;
      if (!last) begin
        pos_q <= step_neg_q ? pos_q - 1'b1 : pos_q + 1'b1;
        acc_q <= acc_q + $signed({{(AccW - SlopeW){slope_step_q[SlopeW-1]}}, slope_step_q});
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_address_o = addr_q;
  assign pixel_color_o   = color_q;
  assign target_buffer_o = buf_q;
  assign last_pixel_o    = last_q;

endmodule
